### rtl/hbcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbcd_pkg - shared definitions for the HTTP body chunked decoder
// Field widths, limits, phase codes, error codes and the hex digit decoder.
// ----------------------------------------------------------------------------
package hbcd_pkg;

  localparam int LEN_W   = 27;
  localparam int LINE_W  = 14;
  localparam int PHASE_W = 3;
  localparam int ERR_W   = 3;
  localparam int CFG_IDX_W = 1;

  typedef logic [LEN_W-1:0]   len_t;
  typedef logic [LINE_W-1:0]  line_t;
  typedef logic [PHASE_W-1:0] phase_t;
  typedef logic [ERR_W-1:0]   err_t;

  localparam len_t  MAX_BODY_BYTES = 27'd67108864;
  localparam line_t MAX_LINE_BYTES = 14'd10000;
  localparam len_t  LEN_SAT        = '1;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_HT = 8'h09;
  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;

  localparam logic [CFG_IDX_W-1:0] REG_CHUNKED_MODE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONTENT_LENGTH = 1'd1;

  localparam phase_t PH_START      = 3'd0;
  localparam phase_t PH_LEN_DATA   = 3'd1;
  localparam phase_t PH_SIZE_LINE  = 3'd2;
  localparam phase_t PH_CHUNK_DATA = 3'd3;
  localparam phase_t PH_CR_DATA    = 3'd4;
  localparam phase_t PH_LF_DATA    = 3'd5;
  localparam phase_t PH_CR_LAST    = 3'd6;
  localparam phase_t PH_LF_LAST    = 3'd7;

  localparam err_t ERR_NONE       = 3'd0;
  localparam err_t ERR_NO_HEX     = 3'd1;
  localparam err_t ERR_LINE_LONG  = 3'd2;
  localparam err_t ERR_OVER_LIMIT = 3'd3;
  localparam err_t ERR_BAD_CRLF   = 3'd4;
  localparam err_t ERR_BAD_LENGTH = 3'd5;

  // Bit 4 flags a hex digit, bits 3:0 carry its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

### rtl/hbcd_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbcd_in_if - input stream channel
// Carries one raw body stream byte per transaction with valid and ready.
// ----------------------------------------------------------------------------
interface hbcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

### rtl/hbcd_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbcd_out_if - result channel
// Carries one decoded result per transaction with valid and ready.
// ----------------------------------------------------------------------------
interface hbcd_out_if;
  logic              valid;
  logic              ready;
  logic [7:0]        body_byte;
  logic              has_byte;
  logic              finished;
  hbcd_pkg::err_t    error_code;

  modport source (output valid, output body_byte, output has_byte, output finished,
                  output error_code, input ready);
  modport sink   (input valid, input body_byte, input has_byte, input finished,
                  input error_code, output ready);
endinterface

### rtl/http_body_chunked_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_body_chunked_decoder_core - HTTP/1.1 message body decoder
// Decodes a body in content-length or chunked transfer coding, one byte per
// transaction, and reports payload bytes, the end of the body and errors.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Carries
//   in_ch     sink       stream_byte: raw body stream byte
//   out_ch    source     body_byte, has_byte, finished, error_code
//   cfg_*     write      chunked_mode (index 0), content_length (index 1)
//
// Each byte is decoded in the cycle it is accepted, and any result lands in
// the output register on the same edge, so a result appears in the cycle after.
// One byte per cycle is sustained while the sink keeps up; the output register is the only stage.
// The block stalls its input only when a result waits in the output register
// and the sink does not take it that cycle. Reset clears the phase and all
// counters and sets both configuration registers to zero; it takes effect at
// once, with no clearing pass.
// ----------------------------------------------------------------------------
module http_body_chunked_decoder_core (
  input  logic                              clk,
  input  logic                              rst_n,
  hbcd_in_if.sink                           in_ch,
  hbcd_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [hbcd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hbcd_pkg::LEN_W-1:0]        cfg_wdata
);

  // Configuration registers. They are read only on the first byte of a body,
  // so a write between bodies takes effect at the next one.
  logic                chunked_mode_r;
  hbcd_pkg::len_t      content_length_r;

  // Decoder state.
  hbcd_pkg::phase_t    phase_r, phase_nxt;
  hbcd_pkg::len_t      size_accum_r, size_accum_nxt;
  logic                digit_seen_r, digit_seen_nxt;
  logic                digits_closed_r, digits_closed_nxt;
  hbcd_pkg::line_t     line_count_r, line_count_nxt;
  hbcd_pkg::len_t      chunk_remaining_r, chunk_remaining_nxt;
  hbcd_pkg::len_t      total_count_r, total_count_nxt;

  // Output register.
  logic                out_valid_r;
  logic [7:0]          body_byte_r;
  logic                has_byte_r;
  logic                finished_r;
  hbcd_pkg::err_t      error_code_r;

  // Result of the byte being decoded this cycle.
  logic                res_valid;
  logic [7:0]          res_byte;
  logic                res_has;
  logic                res_fin;
  hbcd_pkg::err_t      res_err;

  // Size-line working values: a body in chunked mode opens with a fresh line.
  hbcd_pkg::len_t      ln_acc;
  logic                ln_seen;
  logic                ln_closed;
  hbcd_pkg::line_t     ln_count;
  hbcd_pkg::len_t      ln_total;
  hbcd_pkg::line_t     ln_count_inc;
  logic [hbcd_pkg::LEN_W:0] ln_sum;
  logic [4:0]          hex;
  logic                is_space;

  logic                accept;
  logic                do_line;
  logic                go_start;
  logic [7:0]          b;

  // A new byte is taken whenever the output register is empty or drains now.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.stream_byte;

  assign ln_acc    = (phase_r == hbcd_pkg::PH_START) ? '0 : size_accum_r;
  assign ln_seen   = (phase_r == hbcd_pkg::PH_START) ? 1'b0 : digit_seen_r;
  assign ln_closed = (phase_r == hbcd_pkg::PH_START) ? 1'b0 : digits_closed_r;
  assign ln_count  = (phase_r == hbcd_pkg::PH_START) ? '0 : line_count_r;
  assign ln_total  = (phase_r == hbcd_pkg::PH_START) ? '0 : total_count_r;

  assign ln_count_inc = ln_count + hbcd_pkg::line_t'(1);
  assign ln_sum       = {1'b0, ln_total} + {1'b0, ln_acc};
  assign hex          = hbcd_pkg::hex_digit(b);
  assign is_space     = (b == hbcd_pkg::CH_SP) || (b == hbcd_pkg::CH_HT) ||
                        (b == hbcd_pkg::CH_VT) || (b == hbcd_pkg::CH_FF) ||
                        (b == hbcd_pkg::CH_CR);

  always_comb begin
    phase_nxt           = phase_r;
    size_accum_nxt      = size_accum_r;
    digit_seen_nxt      = digit_seen_r;
    digits_closed_nxt   = digits_closed_r;
    line_count_nxt      = line_count_r;
    chunk_remaining_nxt = chunk_remaining_r;
    total_count_nxt     = total_count_r;
    res_valid           = 1'b0;
    res_byte            = '0;
    res_has             = 1'b0;
    res_fin             = 1'b0;
    res_err             = hbcd_pkg::ERR_NONE;
    do_line             = 1'b0;
    go_start            = 1'b0;

    unique case (phase_r)
      hbcd_pkg::PH_START: begin
        if (chunked_mode_r) begin
          do_line = 1'b1;
        end else if (content_length_r == '0 ||
                     content_length_r > hbcd_pkg::MAX_BODY_BYTES) begin
          res_valid = 1'b1;
          res_err   = hbcd_pkg::ERR_BAD_LENGTH;
          go_start  = 1'b1;
        end else if (content_length_r == hbcd_pkg::len_t'(1)) begin
          res_valid = 1'b1;
          res_byte  = b;
          res_has   = 1'b1;
          res_fin   = 1'b1;
          go_start  = 1'b1;
        end else begin
          res_valid           = 1'b1;
          res_byte            = b;
          res_has             = 1'b1;
          chunk_remaining_nxt = content_length_r - hbcd_pkg::len_t'(1);
          phase_nxt           = hbcd_pkg::PH_LEN_DATA;
        end
      end
      hbcd_pkg::PH_LEN_DATA: begin
        res_valid = 1'b1;
        res_byte  = b;
        res_has   = 1'b1;
        if (chunk_remaining_r <= hbcd_pkg::len_t'(1)) begin
          res_fin  = 1'b1;
          go_start = 1'b1;
        end else begin
          chunk_remaining_nxt = chunk_remaining_r - hbcd_pkg::len_t'(1);
        end
      end
      hbcd_pkg::PH_SIZE_LINE: begin
        do_line = 1'b1;
      end
      hbcd_pkg::PH_CHUNK_DATA: begin
        res_valid = 1'b1;
        res_byte  = b;
        res_has   = 1'b1;
        if (chunk_remaining_r <= hbcd_pkg::len_t'(1)) begin
          chunk_remaining_nxt = '0;
          phase_nxt           = hbcd_pkg::PH_CR_DATA;
        end else begin
          chunk_remaining_nxt = chunk_remaining_r - hbcd_pkg::len_t'(1);
        end
      end
      hbcd_pkg::PH_CR_DATA, hbcd_pkg::PH_CR_LAST: begin
        if (b != hbcd_pkg::CH_CR) begin
          res_valid = 1'b1;
          res_err   = hbcd_pkg::ERR_BAD_CRLF;
          go_start  = 1'b1;
        end else begin
          phase_nxt = (phase_r == hbcd_pkg::PH_CR_DATA) ? hbcd_pkg::PH_LF_DATA
                                                        : hbcd_pkg::PH_LF_LAST;
        end
      end
      hbcd_pkg::PH_LF_DATA: begin
        if (b != hbcd_pkg::CH_LF) begin
          res_valid = 1'b1;
          res_err   = hbcd_pkg::ERR_BAD_CRLF;
          go_start  = 1'b1;
        end else begin
          phase_nxt         = hbcd_pkg::PH_SIZE_LINE;
          size_accum_nxt    = '0;
          digit_seen_nxt    = 1'b0;
          digits_closed_nxt = 1'b0;
          line_count_nxt    = '0;
        end
      end
      hbcd_pkg::PH_LF_LAST: begin
        res_valid = 1'b1;
        go_start  = 1'b1;
        if (b != hbcd_pkg::CH_LF) begin
          res_err = hbcd_pkg::ERR_BAD_CRLF;
        end else begin
          res_fin = 1'b1;
        end
      end
      default: begin
        go_start = 1'b1;
      end
    endcase

    // Size-line byte: an LF closes the line, anything else counts toward its
    // length and feeds the hex digit parser until the digits are closed.
    if (do_line) begin
      phase_nxt         = hbcd_pkg::PH_SIZE_LINE;
      size_accum_nxt    = ln_acc;
      digit_seen_nxt    = ln_seen;
      digits_closed_nxt = ln_closed;
      line_count_nxt    = ln_count;
      total_count_nxt   = ln_total;
      if (b == hbcd_pkg::CH_LF) begin
        if (!ln_seen) begin
          res_valid = 1'b1;
          res_err   = hbcd_pkg::ERR_NO_HEX;
          go_start  = 1'b1;
        end else if (ln_acc == '0) begin
          phase_nxt = hbcd_pkg::PH_CR_LAST;
        end else if (ln_sum > {1'b0, hbcd_pkg::MAX_BODY_BYTES}) begin
          res_valid = 1'b1;
          res_err   = hbcd_pkg::ERR_OVER_LIMIT;
          go_start  = 1'b1;
        end else begin
          total_count_nxt     = ln_sum[hbcd_pkg::LEN_W-1:0];
          chunk_remaining_nxt = ln_acc;
          phase_nxt           = hbcd_pkg::PH_CHUNK_DATA;
        end
      end else if (ln_count_inc > hbcd_pkg::MAX_LINE_BYTES) begin
        res_valid = 1'b1;
        res_err   = hbcd_pkg::ERR_LINE_LONG;
        go_start  = 1'b1;
      end else begin
        line_count_nxt = ln_count_inc;
        if (!ln_closed) begin
          if (hex[4]) begin
            // The accumulator saturates once a shift would lose bits.
            size_accum_nxt = (ln_acc[hbcd_pkg::LEN_W-1:hbcd_pkg::LEN_W-4] != 4'd0) ?
                             hbcd_pkg::LEN_SAT : {ln_acc[hbcd_pkg::LEN_W-5:0], hex[3:0]};
            digit_seen_nxt = 1'b1;
          end else if (!(!ln_seen && is_space)) begin
            digits_closed_nxt = 1'b1;
          end
        end
      end
    end

    // Errors and finished bodies return to the start of a new body.
    if (go_start) begin
      phase_nxt           = hbcd_pkg::PH_START;
      size_accum_nxt      = '0;
      digit_seen_nxt      = 1'b0;
      digits_closed_nxt   = 1'b0;
      line_count_nxt      = '0;
      chunk_remaining_nxt = '0;
      total_count_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunked_mode_r   <= 1'b0;
      content_length_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hbcd_pkg::REG_CHUNKED_MODE:   chunked_mode_r   <= cfg_wdata[0];
        hbcd_pkg::REG_CONTENT_LENGTH: content_length_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r           <= hbcd_pkg::PH_START;
      size_accum_r      <= '0;
      digit_seen_r      <= 1'b0;
      digits_closed_r   <= 1'b0;
      line_count_r      <= '0;
      chunk_remaining_r <= '0;
      total_count_r     <= '0;
    end else if (accept) begin
      phase_r           <= phase_nxt;
      size_accum_r      <= size_accum_nxt;
      digit_seen_r      <= digit_seen_nxt;
      digits_closed_r   <= digits_closed_nxt;
      line_count_r      <= line_count_nxt;
      chunk_remaining_r <= chunk_remaining_nxt;
      total_count_r     <= total_count_nxt;
    end
  end

  // The output register loads a new result or empties when its transaction
  // completes; a byte that yields no result just drains it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= res_valid;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      body_byte_r  <= res_byte;
      has_byte_r   <= res_has;
      finished_r   <= res_fin;
      error_code_r <= res_err;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.body_byte  = body_byte_r;
  assign out_ch.has_byte   = has_byte_r;
  assign out_ch.finished   = finished_r;
  assign out_ch.error_code = error_code_r;

endmodule
